/* rtl/core/ctmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmf_pkg
// Shared types and constants of the clamped temporal median filter core.
// ----------------------------------------------------------------------------
package ctmf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MEDIAN_W   = 17;
  localparam int CHANNEL_W  = 6;
  localparam int DEPTH_W    = 3;
  localparam int COUNT_W    = 7;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_RANGE_MIN     = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX     = 2'd1;
  localparam logic [1:0] REG_HISTORY_DEPTH = 2'd2;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

  localparam logic [SAMPLE_W-1:0] RANGE_MIN_RST     = 16'd0;
  localparam logic [SAMPLE_W-1:0] RANGE_MAX_RST     = 16'd5120;
  localparam logic [DEPTH_W-1:0]  HISTORY_DEPTH_RST = 3'd3;
  localparam logic [COUNT_W-1:0]  CHANNEL_COUNT_RST = 7'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RANK,
    ST_SEL
  } ctmf_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic rank;
    logic out_load;
  } ctmf_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ctmf_sts_t;

endpackage

/* rtl/core/clamped_temporal_median_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_temporal_median_filter_core
// Range clamp, round robin channel assignment and per-channel temporal median.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel: one raw 8.8 sample per beat (in_valid / in_stall).
//   out_* channel: one result per input beat, twice the median of the
//   channel's window, with the channel index (out_valid / out_stall).
//   cfg_* port: APB-style writes of range_min, range_max, history_depth and
//   channel_count at byte addresses 0, 4, 8, 12; write only while idle.
// Sequence:
//   an item passes through accept and window row read, row update and write
//   back, rank counting over the window lanes, and median select into the output
//   register. The next beat is taken only once the item has left its select
//   step, so a new beat is not accepted while an item is in work.
// Reset:
//   rst_n clears the pointer and control; afterwards a clearing pass over all
//   MAX_CHANNELS rows zeroes the fill counts, with in_stall held high.
// Stall:
//   a finished result waits in the output register while the next item is
//   worked on; that item then holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module clamped_temporal_median_filter_core #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_WINDOW   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ctmf_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ctmf_pkg::MEDIAN_W-1:0]       out_median_twice,
  output logic [ctmf_pkg::CHANNEL_W-1:0]      out_channel,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ctmf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ctmf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ctmf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  logic [ctmf_pkg::SAMPLE_W-1:0] range_min_r, range_max_r;
  logic [ctmf_pkg::DEPTH_W-1:0]  history_depth_r;
  logic [ctmf_pkg::COUNT_W-1:0]  channel_count_r;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r     <= ctmf_pkg::RANGE_MIN_RST;
      range_max_r     <= ctmf_pkg::RANGE_MAX_RST;
      history_depth_r <= ctmf_pkg::HISTORY_DEPTH_RST;
      channel_count_r <= ctmf_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ctmf_pkg::REG_RANGE_MIN:     range_min_r     <= cfg_pwdata[ctmf_pkg::SAMPLE_W-1:0];
        ctmf_pkg::REG_RANGE_MAX:     range_max_r     <= cfg_pwdata[ctmf_pkg::SAMPLE_W-1:0];
        ctmf_pkg::REG_HISTORY_DEPTH: history_depth_r <= cfg_pwdata[ctmf_pkg::DEPTH_W-1:0];
        ctmf_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_pwdata[ctmf_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ctmf_pkg::REG_RANGE_MIN:     cfg_prdata = ctmf_pkg::CFG_DATA_W'(range_min_r);
      ctmf_pkg::REG_RANGE_MAX:     cfg_prdata = ctmf_pkg::CFG_DATA_W'(range_max_r);
      ctmf_pkg::REG_HISTORY_DEPTH: cfg_prdata = ctmf_pkg::CFG_DATA_W'(history_depth_r);
      ctmf_pkg::REG_CHANNEL_COUNT: cfg_prdata = ctmf_pkg::CFG_DATA_W'(channel_count_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  ctmf_pkg::ctmf_cmd_t cmd;
  ctmf_pkg::ctmf_sts_t sts;

  ctmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctmf_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .range_min        (range_min_r),
    .range_max        (range_max_r),
    .history_depth    (history_depth_r),
    .channel_count    (channel_count_r),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_twice (out_median_twice),
    .out_channel      (out_channel)
  );

endmodule

/* rtl/core/ctmf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ctmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/ctmf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmf_ctrl
// Sequencer: clearing pass after reset, then read, rank and select per beat.
// ----------------------------------------------------------------------------
module ctmf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ctmf_pkg::ctmf_sts_t sts,
  output ctmf_pkg::ctmf_cmd_t cmd
);

  ctmf_pkg::ctmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctmf_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctmf_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ctmf_pkg::ST_IDLE;
      end
      ctmf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ctmf_pkg::ST_READ;
      end
      ctmf_pkg::ST_READ: state_nxt = ctmf_pkg::ST_RANK;
      ctmf_pkg::ST_RANK: state_nxt = ctmf_pkg::ST_SEL;
      ctmf_pkg::ST_SEL: begin
        if (sts.out_free) state_nxt = ctmf_pkg::ST_IDLE;
      end
      default: state_nxt = ctmf_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ctmf_pkg::ST_CLEAR: cmd.clear = 1'b1;
      ctmf_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ctmf_pkg::ST_READ: cmd.update = 1'b1;
      ctmf_pkg::ST_RANK: cmd.rank = 1'b1;
      ctmf_pkg::ST_SEL:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/ctmf_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmf_dpath
// Clamp, channel pointer, per-channel window store, rank selection and the
// output register.
// ----------------------------------------------------------------------------
module ctmf_dpath #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_WINDOW   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctmf_pkg::ctmf_cmd_t                 cmd,
  output ctmf_pkg::ctmf_sts_t                 sts,
  input  logic [ctmf_pkg::SAMPLE_W-1:0]       range_min,
  input  logic [ctmf_pkg::SAMPLE_W-1:0]       range_max,
  input  logic [ctmf_pkg::DEPTH_W-1:0]        history_depth,
  input  logic [ctmf_pkg::COUNT_W-1:0]        channel_count,
  input  logic [ctmf_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ctmf_pkg::MEDIAN_W-1:0]       out_median_twice,
  output logic [ctmf_pkg::CHANNEL_W-1:0]      out_channel
);

  localparam int SW       = ctmf_pkg::SAMPLE_W;
  localparam int CH_IDX_W = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
  localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W    = ($clog2(MAX_CHANNELS + 1) > ctmf_pkg::COUNT_W ?
                             $clog2(MAX_CHANNELS + 1) : ctmf_pkg::COUNT_W) + 1;
  localparam int WIN_W    = (FILL_W > ctmf_pkg::DEPTH_W ? FILL_W : ctmf_pkg::DEPTH_W) + 1;
  localparam int ROW_W    = SW * MAX_WINDOW;

  // ---- channel pointer and clamp
  logic [CH_IDX_W-1:0] ptr_r, ptr_nxt, ch_sel, ch_r;
  logic [CMP_W-1:0]    count_eff, cc_ext;
  logic [SW-1:0]       s_lo, s_clamp, sample_r;

  assign cc_ext    = CMP_W'(channel_count);
  assign count_eff = (channel_count == '0) ? CMP_W'(1) :
                     (cc_ext > CMP_W'(MAX_CHANNELS)) ? CMP_W'(MAX_CHANNELS) : cc_ext;
  assign ch_sel    = (CMP_W'(ptr_r) >= count_eff) ? '0 : ptr_r;
  assign ptr_nxt   = (CMP_W'(ch_sel) + CMP_W'(1) >= count_eff) ? '0 :
                     ch_sel + CH_IDX_W'(1);
  assign s_lo      = (in_sample < range_min) ? range_min : in_sample;
  assign s_clamp   = (s_lo > range_max) ? range_max : s_lo;

  // ---- clearing pass over the fill counts
  logic [CH_IDX_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      clr_idx_r <= '0;
    end else begin
      if (cmd.accept) ptr_r <= ptr_nxt;
      if (cmd.clear)  clr_idx_r <= clr_idx_r + CH_IDX_W'(1);
    end
  end

  assign sts.clear_last = (clr_idx_r == CH_IDX_W'(MAX_CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= s_clamp;
      ch_r     <= ch_sel;
    end
  end

  // ---- window store: newest sample in lane 0, one row per channel
  logic [ROW_W-1:0]    hist_rdata, hist_wdata;
  logic [FILL_W-1:0]   fill_rdata, fill_new, fill_wdata;
  logic [CH_IDX_W-1:0] fill_waddr;

  always_comb begin
    hist_wdata[SW-1:0] = sample_r;
    for (int k = 1; k < MAX_WINDOW; k++) begin
      hist_wdata[k*SW +: SW] = hist_rdata[(k-1)*SW +: SW];
    end
  end

  assign fill_new   = (fill_rdata >= FILL_W'(MAX_WINDOW)) ? FILL_W'(MAX_WINDOW) :
                      fill_rdata + FILL_W'(1);
  assign fill_wdata = cmd.clear ? '0 : fill_new;
  assign fill_waddr = cmd.clear ? clr_idx_r : ch_r;

  ctmf_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CHANNELS)) u_hist_ram (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (ch_r),
    .wr_data (hist_wdata),
    .rd_addr (ch_sel),
    .rd_data (hist_rdata)
  );

  ctmf_ram #(.WIDTH(FILL_W), .DEPTH(MAX_CHANNELS)) u_fill_ram (
    .clk     (clk),
    .wr_en   (cmd.update | cmd.clear),
    .wr_addr (fill_waddr),
    .wr_data (fill_wdata),
    .rd_addr (ch_sel),
    .rd_data (fill_rdata)
  );

  // ---- window length
  logic [WIN_W-1:0]  win_ext, win_cap;
  logic [FILL_W-1:0] n_nxt, n_r;

  assign win_ext = WIN_W'(history_depth) + WIN_W'(1);
  assign win_cap = (win_ext > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_ext;
  assign n_nxt   = (WIN_W'(fill_new) < win_cap) ? fill_new : FILL_W'(win_cap);

  logic [SW-1:0] vals_r [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      n_r <= n_nxt;
      for (int k = 0; k < MAX_WINDOW; k++) begin
        vals_r[k] <= hist_wdata[k*SW +: SW];
      end
    end
  end

  // ---- rank counts: how many lanes lie below and up to each lane
  logic [MAX_WINDOW-1:0] lane_on;
  logic [FILL_W-1:0]     below_c [MAX_WINDOW];
  logic [FILL_W-1:0]     upto_c  [MAX_WINDOW];
  logic [FILL_W-1:0]     below_r [MAX_WINDOW];
  logic [FILL_W-1:0]     upto_r  [MAX_WINDOW];

  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      lane_on[j] = (FILL_W'(j) < n_r);
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      below_c[i] = '0;
      upto_c[i]  = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        below_c[i] = below_c[i] + FILL_W'(lane_on[j] && (vals_r[j] <  vals_r[i]));
        upto_c[i]  = upto_c[i]  + FILL_W'(lane_on[j] && (vals_r[j] <= vals_r[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rank) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        below_r[i] <= below_c[i];
        upto_r[i]  <= upto_c[i];
      end
    end
  end

  // ---- selection: all lanes that hold a rank carry the same value, so or them
  logic [FILL_W-1:0]               k_hi, k_lo;
  logic [SW-1:0]                   v_hi, v_lo;
  logic [ctmf_pkg::MEDIAN_W-1:0]   median_sum;

  assign k_hi = n_r >> 1;
  assign k_lo = n_r[0] ? k_hi : k_hi - FILL_W'(1);

  always_comb begin
    v_hi = '0;
    v_lo = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (lane_on[i] && below_r[i] <= k_hi && k_hi < upto_r[i]) v_hi = v_hi | vals_r[i];
      if (lane_on[i] && below_r[i] <= k_lo && k_lo < upto_r[i]) v_lo = v_lo | vals_r[i];
    end
  end

  assign median_sum = ctmf_pkg::MEDIAN_W'(v_hi) + ctmf_pkg::MEDIAN_W'(v_lo);

  // ---- output register
  logic                             out_valid_r, out_valid_nxt;
  logic [ctmf_pkg::MEDIAN_W-1:0]    out_median_r;
  logic [ctmf_pkg::CHANNEL_W-1:0]   out_channel_r;

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_median_r  <= median_sum;
      out_channel_r <= ctmf_pkg::CHANNEL_W'(ch_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_twice = out_median_r;
  assign out_channel      = out_channel_r;

  // ---- checks
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an unaccepted beat");

  a_window_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rank |-> (n_r != '0 && n_r <= FILL_W'(MAX_WINDOW)))
    else $error("window length out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (fill_rdata <= FILL_W'(MAX_WINDOW)))
    else $error("stored fill count above window capacity");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !cmd.accept && !cmd.update)
    else $error("item work during clearing pass");

endmodule
